// ===== rtl/core/fbb_pkg.sv =====
// ----------------------------------------------------------------------------
// Free block bitmap package
// Shared sizes, action codes, sequencer states and interface structs.
// ----------------------------------------------------------------------------
package fbb_pkg;

  localparam int unsigned FBB_MAX_ENTRIES = 1024;
  localparam int unsigned FBB_IDX_W       = $clog2(FBB_MAX_ENTRIES);
  localparam int unsigned FBB_CNT_W       = FBB_IDX_W + 1;
  localparam int unsigned FBB_CFG_W       = 11;
  localparam int unsigned FBB_BYTES       = (FBB_MAX_ENTRIES + 7) / 8;
  localparam int unsigned FBB_ADDR_W      = $clog2(FBB_BYTES);
  localparam int unsigned FBB_NBYTES_W    = FBB_CNT_W - 3;

  typedef enum logic [2:0] {
    ACT_READ      = 3'd0,
    ACT_SET       = 3'd1,
    ACT_CLEAR     = 3'd2,
    ACT_SET_ALL   = 3'd3,
    ACT_CLEAR_ALL = 3'd4,
    ACT_FIND      = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    BU_NONE,
    BU_SET,
    BU_CLEAR,
    BU_FILL_ONE,
    BU_FILL_ZERO
  } byte_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_FILL,
    ST_FIND,
    ST_RESULT
  } state_e;

  // Request from the sequencer to the byte store.
  typedef struct packed {
    logic                  rd;
    logic                  wr;
    logic [FBB_ADDR_W-1:0] addr;
    logic [7:0]            wdata;
  } mem_req_t;

  // One result; the last field sits in the lowest bit.
  typedef struct packed {
    logic                 out_of_range;
    logic [FBB_IDX_W-1:0] found_index;
    logic                 found;
    logic                 bit_value;
  } result_t;

endpackage

// ===== rtl/core/fbb_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fbb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/fbb_byte_unit.sv =====
// ----------------------------------------------------------------------------
// Bitmap byte unit
// Shared byte datapath: bit test, bit update, byte fill and first-clear search.
// ----------------------------------------------------------------------------
module fbb_byte_unit (
  input  fbb_pkg::byte_op_e op_i,
  input  logic [7:0]        byte_i,
  input  logic [2:0]        pos_i,
  input  logic [3:0]        nvalid_i,
  output logic [7:0]        byte_o,
  output logic              bit_o,
  output logic              zero_found_o,
  output logic [2:0]        zero_pos_o
);
  import fbb_pkg::*;

  logic [7:0] mask;

  // Entry k of a byte lives at bit 7-k.
  assign mask  = 8'h80 >> pos_i;
  assign bit_o = |(byte_i & mask);

  always_comb begin
    case (op_i)
      BU_SET:       byte_o = byte_i | mask;
      BU_CLEAR:     byte_o = byte_i & ~mask;
      BU_FILL_ONE:  byte_o = 8'hFF;
      BU_FILL_ZERO: byte_o = 8'h00;
      default:      byte_o = byte_i;
    endcase
  end

  // Lowest clear entry among the first nvalid entries of the byte.
  always_comb begin
    zero_found_o = 1'b0;
    zero_pos_o   = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (!byte_i[7-k] && (4'(k) < nvalid_i)) begin
        zero_found_o = 1'b1;
        zero_pos_o   = 3'(k);
      end
    end
  end

endmodule

// ===== rtl/core/fbb_ctrl.sv =====
// ----------------------------------------------------------------------------
// Bitmap sequencer
// Walks the byte store for each action and drives the shared byte unit.
// ----------------------------------------------------------------------------
module fbb_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [fbb_pkg::FBB_CNT_W-1:0] count_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  fbb_pkg::action_e              act_i,
  input  logic [fbb_pkg::FBB_IDX_W-1:0] idx_i,
  output fbb_pkg::mem_req_t             mem_req_o,
  input  logic [7:0]                    rdata_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output fbb_pkg::result_t              res_o
);
  import fbb_pkg::*;

  state_e                  state_q, state_d;
  action_e                 act_q, act_d;
  logic [FBB_IDX_W-1:0]    idx_q, idx_d;
  logic [FBB_ADDR_W-1:0]   addr_q, addr_d;
  result_t                 res_q, res_d;

  logic [FBB_CNT_W-1:0]    cnt_pad;
  logic [FBB_NBYTES_W-1:0] nbytes;
  logic [FBB_NBYTES_W-1:0] last_byte;
  logic [FBB_ADDR_W-1:0]   last_addr;
  logic                    no_bytes;
  logic                    idx_oor;
  logic [FBB_CNT_W-1:0]    rem;
  logic [3:0]              find_nvalid;

  byte_op_e                bu_op;
  logic [2:0]              bu_pos;
  logic [3:0]              bu_nvalid;
  logic [7:0]              bu_byte;
  logic                    bu_bit;
  logic                    bu_zero_found;
  logic [2:0]              bu_zero_pos;

  // Bytes covering the entries in use: ceil(count / 8).
  assign cnt_pad   = count_i + FBB_CNT_W'(7);
  assign nbytes    = cnt_pad[FBB_CNT_W-1:3];
  assign last_byte = nbytes - 1'b1;
  assign last_addr = last_byte[FBB_ADDR_W-1:0];
  assign no_bytes  = (nbytes == '0);
  assign idx_oor   = ({1'b0, idx_i} >= count_i);

  // Entries of the byte under test that still lie below the count.
  assign rem         = count_i - FBB_CNT_W'({addr_q, 3'b000});
  assign find_nvalid = (rem >= FBB_CNT_W'(8)) ? 4'd8 : rem[3:0];

  fbb_byte_unit u_byte_unit (
    .op_i         (bu_op),
    .byte_i       (rdata_i),
    .pos_i        (bu_pos),
    .nvalid_i     (bu_nvalid),
    .byte_o       (bu_byte),
    .bit_o        (bu_bit),
    .zero_found_o (bu_zero_found),
    .zero_pos_o   (bu_zero_pos)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (act_i)
            ACT_READ, ACT_SET, ACT_CLEAR: state_d = idx_oor ? ST_RESULT : ST_ACCESS;
            ACT_SET_ALL, ACT_CLEAR_ALL:   state_d = no_bytes ? ST_RESULT : ST_FILL;
            ACT_FIND:                     state_d = no_bytes ? ST_RESULT : ST_FIND;
            default:                      state_d = ST_RESULT;
          endcase
        end
      end
      ST_ACCESS: state_d = ST_RESULT;
      ST_FILL: begin
        if (addr_q == last_addr) begin
          state_d = ST_RESULT;
        end
      end
      ST_FIND: begin
        if (bu_zero_found || (addr_q == last_addr)) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    act_d       = act_q;
    idx_d       = idx_q;
    addr_d      = addr_q;
    res_d       = res_q;
    mem_req_o   = '0;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    bu_op       = BU_NONE;
    bu_pos      = idx_q[2:0];
    bu_nvalid   = find_nvalid;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          act_d  = act_i;
          idx_d  = idx_i;
          addr_d = '0;
          res_d  = '0;
          case (act_i)
            ACT_READ, ACT_SET, ACT_CLEAR: begin
              if (idx_oor) begin
                res_d.out_of_range = 1'b1;
              end else begin
                mem_req_o.rd   = 1'b1;
                mem_req_o.addr = idx_i[FBB_IDX_W-1:3];
              end
            end
            ACT_FIND: begin
              mem_req_o.rd   = !no_bytes;
              mem_req_o.addr = '0;
            end
            default: ;
          endcase
        end
      end
      ST_ACCESS: begin
        if (act_q == ACT_SET) begin
          bu_op = BU_SET;
        end else if (act_q == ACT_CLEAR) begin
          bu_op = BU_CLEAR;
        end
        if (act_q inside {ACT_SET, ACT_CLEAR}) begin
          mem_req_o.wr    = 1'b1;
          mem_req_o.addr  = idx_q[FBB_IDX_W-1:3];
          mem_req_o.wdata = bu_byte;
        end
        res_d.bit_value = (act_q == ACT_READ) && bu_bit;
      end
      ST_FILL: begin
        bu_op           = (act_q == ACT_SET_ALL) ? BU_FILL_ONE : BU_FILL_ZERO;
        mem_req_o.wr    = 1'b1;
        mem_req_o.addr  = addr_q;
        mem_req_o.wdata = bu_byte;
        addr_d          = addr_q + 1'b1;
      end
      ST_FIND: begin
        if (bu_zero_found) begin
          res_d.found       = 1'b1;
          res_d.found_index = {addr_q, bu_zero_pos};
        end else begin
          // Reads run one byte ahead of the test; a read past the end is unused.
          mem_req_o.rd   = 1'b1;
          mem_req_o.addr = addr_q + 1'b1;
          addr_d         = addr_q + 1'b1;
        end
      end
      ST_RESULT: begin
        res_valid_o = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      act_q   <= ACT_READ;
      addr_q  <= '0;
    end else begin
      state_q <= state_d;
      act_q   <= act_d;
      addr_q  <= addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

// ===== rtl/core/free_block_bitmap.sv =====
// ----------------------------------------------------------------------------
// Free block bitmap
// Block-in-use bitmap over up to 1024 entries, stored as 128 bytes with the
// most significant bit first, with single-bit and whole-map actions.
// ----------------------------------------------------------------------------
// Steps: an out-of-range or unused action goes straight to its result, and
// read/set/clear pass the access state; set-all/clear-all fill the N bytes,
// N = ceil(count/8) <= 128, and find tests them in turn up to a clear entry.
// Throughput: one item at a time; the byte store port and the byte unit
// serve one byte per cycle, so the next item waits until this one is done.
// Reset: the store reads as all zeros at once through per-byte valid flags.
// ----------------------------------------------------------------------------
module free_block_bitmap (
  input  logic        clk_i,
  input  logic        rst_ni,

  // Configuration: entries_in_use.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fbb_pkg::FBB_CFG_W-1:0] cfg_data_i,

  // Input items.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [9:0] entry_index
  input  logic [2:0]  s_axis_tuser,  // [2:0] action

  // Results.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // [0] bit_value, [1] found,
                                     // [11:2] found_index, [12] out_of_range
);
  import fbb_pkg::*;

  logic [FBB_CFG_W-1:0]  entries_q;
  logic [FBB_CNT_W-1:0]  count_eff;

  mem_req_t              mem_req;
  logic [7:0]            ram_rdata;
  logic [7:0]            rdata;
  logic [FBB_BYTES-1:0]  byte_vld_q;
  logic                  rd_vld_q;

  logic                  res_valid;
  logic                  res_ready;
  result_t               res;
  logic                  out_valid_q;
  result_t               out_res_q;

  // The entry count register accepts a transfer in every cycle. Counts
  // beyond the capacity saturate to the capacity.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= FBB_CFG_W'(FBB_MAX_ENTRIES);
    end else if (cfg_valid_i) begin
      entries_q <= cfg_data_i;
    end
  end

  assign count_eff = (entries_q > FBB_CFG_W'(FBB_MAX_ENTRIES))
                   ? FBB_CNT_W'(FBB_MAX_ENTRIES) : FBB_CNT_W'(entries_q);

  // Byte store. A byte that was never written since reset has its valid
  // flag low and reads as zero, which stands in for clearing at reset.
  fbb_ram #(
    .WIDTH (8),
    .DEPTH (FBB_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.wr),
    .waddr_i (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.rd),
    .raddr_i (mem_req.addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q <= '0;
      rd_vld_q   <= 1'b0;
    end else begin
      if (mem_req.wr) begin
        byte_vld_q[mem_req.addr] <= 1'b1;
      end
      if (mem_req.rd) begin
        rd_vld_q <= byte_vld_q[mem_req.addr];
      end
    end
  end

  assign rdata = rd_vld_q ? ram_rdata : 8'h00;

  // Sequencer with the shared byte unit.
  fbb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .count_i     (count_eff),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .act_i       (action_e'(s_axis_tuser)),
    .idx_i       (s_axis_tdata[FBB_IDX_W-1:0]),
    .mem_req_o   (mem_req),
    .rdata_i     (rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register. It parts the result side from the sequencer, so a new
  // item can be taken while the previous result still waits for transfer.
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = 16'(out_res_q);

  // The sequencer is busy in the cycle after it takes an item.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while the previous item was in progress");

  // A found entry always lies below the entry count.
  a_found_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res.found) |-> ({1'b0, res.found_index} < count_eff))
    else $error("find reported an entry at or beyond the count");

  // A result handed over is presented on the output the next cycle.
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_ready) |=> (out_valid_q && (out_res_q == $past(res))))
    else $error("result lost between sequencer and output register");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Free block bitmap testbench
// Drives read, set, clear, set-all, clear-all and find-first-clear requests
// under several entry counts. A scoreboard mirrors the bitmap, predicts each
// result and checks every returned transfer field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
  import fbb_pkg::*;

  // Action codes the block treats as unused; they must come back all zero.
  localparam logic [2:0] ACT_SPARE_A = 3'd6;
  localparam logic [2:0] ACT_SPARE_B = 3'd7;

  // The slowest item walks all 128 bytes; with the longest sender gap and
  // receiver stall on every item, 1900 items stay well under half this limit.
  localparam int unsigned CYCLE_LIMIT = 2_500_000;
  localparam int unsigned TAIL_CYCLES = 300;
  localparam int unsigned PRINT_CAP   = 20;

  // --------------------------------------------------------------------------
  // Scoreboard: a mirror of the bitmap and the entry count, and the queue of
  // results that are due from the block.
  // --------------------------------------------------------------------------
  class usage_map_tracker;
    logic [7:0]          map_bytes [FBB_BYTES];
    logic [FBB_CFG_W-1:0] count_shadow;
    result_t             due_results [$];
    int unsigned         mismatches;
    int unsigned         actions_noted;
    int unsigned         results_seen;
    int unsigned         finds_hit;

    function new();
      foreach (map_bytes[i]) map_bytes[i] = 8'h00;
      count_shadow  = FBB_CFG_W'(FBB_MAX_ENTRIES);
      mismatches    = 0;
      actions_noted = 0;
      results_seen  = 0;
      finds_hit     = 0;
    endfunction

    function void set_count(logic [FBB_CFG_W-1:0] value);
      count_shadow = value;
    endfunction

    // The count saturates at the capacity of the store.
    function int unsigned live_count();
      return (count_shadow > FBB_MAX_ENTRIES) ? FBB_MAX_ENTRIES : count_shadow;
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction

    function logic entry_bit(int unsigned idx);
      return map_bytes[idx / 8][7 - (idx % 8)];
    endfunction

    // Applies one accepted request to the mirror and queues its result.
    function void note_action(logic [2:0] act, logic [FBB_IDX_W-1:0] idx);
      result_t     want;
      int unsigned lim;
      int unsigned span;
      want = '0;
      lim  = live_count();
      actions_noted++;
      case (act)
        ACT_READ, ACT_SET, ACT_CLEAR: begin
          if (idx >= lim) begin
            want.out_of_range = 1'b1;
          end else if (act == ACT_READ) begin
            want.bit_value = entry_bit(idx);
          end else begin
            map_bytes[idx / 8][7 - (idx % 8)] = (act == ACT_SET);
          end
        end
        ACT_SET_ALL, ACT_CLEAR_ALL: begin
          // Whole bytes are written, so spare bits past the count change too.
          span = (lim + 7) / 8;
          for (int unsigned i = 0; i < span; i++) begin
            map_bytes[i] = (act == ACT_SET_ALL) ? 8'hFF : 8'h00;
          end
        end
        ACT_FIND: begin
          for (int unsigned i = 0; i < lim; i++) begin
            if (!entry_bit(i)) begin
              want.found       = 1'b1;
              want.found_index = FBB_IDX_W'(i);
              finds_hit++;
              break;
            end
          end
        end
        default: begin
        end
      endcase
      due_results.push_back(want);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= PRINT_CAP) $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // Compares one returned transfer with the oldest pending result.
    task check_result(result_t got);
      result_t want;
      results_seen++;
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", got));
        return;
      end
      want = due_results.pop_front();
      if (got.bit_value !== want.bit_value)
        report_mismatch($sformatf("bit_value %b, expected %b", got.bit_value, want.bit_value));
      if (got.found !== want.found)
        report_mismatch($sformatf("found %b, expected %b", got.found, want.found));
      if (got.found_index !== want.found_index)
        report_mismatch($sformatf("found_index %0d, expected %0d",
                                  got.found_index, want.found_index));
      if (got.out_of_range !== want.out_of_range)
        report_mismatch($sformatf("out_of_range %b, expected %b",
                                  got.out_of_range, want.out_of_range));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Signals and the unit under test.
  // --------------------------------------------------------------------------
  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [FBB_CFG_W-1:0] cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [15:0]          s_axis_tdata;
  logic [2:0]           s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [15:0]          m_axis_tdata;

  usage_map_tracker tracker = new();

  int unsigned cycle_count = 0;
  int unsigned ready_hold  = 0;
  int unsigned settings_run = 0;
  bit          steady      = 1'b0;

  free_block_bitmap uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock with a 10 ns period.
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // The run is cut off at a generous cycle count, so a hang cannot go on.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  // Idle lengths: mostly none or short, now and then long. In a steady phase
  // neither side idles, which keeps back-to-back transfers in the mix.
  function automatic int unsigned idle_len();
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: tready alternates between runs of acceptance and stalls.
  always @(posedge clk_i) begin
    if (steady) begin
      m_axis_tready <= 1'b1;
      ready_hold    <= 0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      m_axis_tready <= ~m_axis_tready;
      ready_hold    <= m_axis_tready ? idle_len() : $urandom_range(0, 12);
    end
  end

  // Every result transfer is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      tracker.check_result(result_t'(m_axis_tdata[$bits(result_t)-1:0]));
    end
  end

  // --------------------------------------------------------------------------
  // Request side. Each task is entered at a rising edge. The valid is only
  // lowered when a gap follows, so it is never lowered and raised in one step.
  // --------------------------------------------------------------------------
  task automatic send_item(logic [2:0] act, logic [FBB_IDX_W-1:0] idx);
    int unsigned gap;
    gap = idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {{(16 - FBB_IDX_W){1'b0}}, idx};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    tracker.note_action(act, idx);
  endtask

  // Stops the request stream and waits until every result has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_count(logic [FBB_CFG_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    tracker.set_count(value);
    cfg_valid_i <= 1'b0;
    settings_run++;
  endtask

  // An index below the live count where there is one.
  function automatic logic [FBB_IDX_W-1:0] index_in_use();
    int unsigned lim;
    lim = tracker.live_count();
    if (lim == 0) return FBB_IDX_W'($urandom_range(0, FBB_MAX_ENTRIES - 1));
    return FBB_IDX_W'($urandom_range(0, lim - 1));
  endfunction

  function automatic logic [FBB_IDX_W-1:0] any_index();
    return FBB_IDX_W'($urandom_range(0, FBB_MAX_ENTRIES - 1));
  endfunction

  // Random traffic for one entry-count setting. Most of it fills the map and
  // punches a few holes before a find, so searches end at varied positions.
  task automatic run_traffic(int unsigned budget);
    int unsigned sent;
    int unsigned roll;
    int unsigned holes;
    sent = 0;
    while (sent < budget) begin
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
        send_item(ACT_SET_ALL, any_index());
        holes = $urandom_range(0, 3);
        repeat (holes) send_item(ACT_CLEAR, index_in_use());
        send_item(ACT_FIND, any_index());
        sent += holes + 2;
        if ($urandom_range(0, 1)) begin
          send_item(ACT_READ, index_in_use());
          sent++;
        end
      end else if (roll < 80) begin
        send_item(3'($urandom_range(ACT_READ, ACT_FIND)),
                  ($urandom_range(0, 4) != 0) ? index_in_use() : any_index());
        sent++;
      end else begin
        send_item(3'($urandom_range(0, 7)), any_index());
        sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    logic [FBB_CFG_W-1:0] count_plan [10];
    count_plan = '{11'd9, 11'd0, 11'd1, 11'd2047, 11'd1023,
                   11'd100, 11'd1025, 11'd8, 11'd0, 11'd1024};
    count_plan[8] = FBB_CFG_W'($urandom_range(0, 2047));

    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= ACT_READ;
    m_axis_tready <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset count of 1024 entries: end entries, byte
    // boundaries, a full map with no clear entry, and the unused actions.
    send_item(ACT_READ, 10'd0);
    send_item(ACT_FIND, 10'd1023);
    send_item(ACT_SET, 10'd0);
    send_item(ACT_READ, 10'd0);
    send_item(ACT_SET, 10'd1023);
    send_item(ACT_READ, 10'd1023);
    send_item(ACT_FIND, 10'd0);
    send_item(ACT_SET, 10'd7);
    send_item(ACT_FIND, 10'd0);
    send_item(ACT_CLEAR, 10'd0);
    send_item(ACT_SET_ALL, 10'd1023);
    send_item(ACT_FIND, 10'd0);
    send_item(ACT_READ, 10'd517);
    send_item(ACT_CLEAR, 10'd1023);
    send_item(ACT_FIND, 10'd0);
    send_item(ACT_CLEAR, 10'd8);
    send_item(ACT_FIND, 10'd0);
    send_item(ACT_SPARE_A, 10'd1023);
    send_item(ACT_SPARE_B, 10'd0);
    send_item(ACT_CLEAR_ALL, 10'd0);
    send_item(ACT_READ, 10'd1023);
    send_item(ACT_FIND, 10'd1023);
    drain_results();

    // One phase per entry count: zero, counts inside one byte, counts that
    // leave spare bits in the last byte, the capacity, and above it.
    for (int p = 0; p < 10; p++) begin
      steady = (p % 3 == 2);
      write_count(count_plan[p]);
      run_traffic(188);
      drain_results();
    end

    steady = 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (tracker.pending() != 0)
      tracker.report_mismatch($sformatf("%0d results never arrived", tracker.pending()));

    $display("covered %0d requests over %0d entry-count settings, %0d results checked",
             tracker.actions_noted, settings_run, tracker.results_seen);
    $display("%0d searches found a clear entry, %0d mismatches",
             tracker.finds_hit, tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
